// ===== hdl/irpr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irpr_pkg: shared types and constants of the integer ratio pixel rescaler
// Field widths, line store geometry, configuration codes, controller states
// and the reciprocal tables used for the constant-ratio divisions.
// ----------------------------------------------------------------------------
package irpr_pkg;

  // Field widths
  localparam int SRC_W   = 9;
  localparam int DST_W   = 12;
  localparam int CH_W    = 8;
  localparam int SUM_W   = 14;
  localparam int RATIO_W = 4;
  localparam int NUM_CH  = 4;

  // Line store and ratio limits
  localparam int MAX_COLS  = 512;
  localparam int MAX_RATIO = 8;
  localparam int COL_AW    = $clog2(MAX_COLS);
  localparam int CNT_W     = $clog2(MAX_RATIO);

  // Reciprocal scaling: coordinate quotient and block average quotient
  localparam int COORD_SH = 12;
  localparam int COORD_RW = 13;
  localparam int AREA_SH  = 20;
  localparam int AREA_RW  = 21;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_MODE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_RATIO = 1'b1;

  // Scale modes
  localparam logic MODE_DOWN = 1'b0;
  localparam logic MODE_UP   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QUOT,
    ST_REM,
    ST_SUM,
    ST_AVG,
    ST_EMIT,
    ST_REP
  } irpr_state_t;

  typedef struct packed {
    logic [SRC_W-1:0] src_row;
    logic [SRC_W-1:0] src_col;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic [CH_W-1:0]  alpha;
  } irpr_pixel_t;

  typedef struct packed {
    logic [DST_W-1:0] dst_row;
    logic [DST_W-1:0] dst_col;
    logic [CH_W-1:0]  out_red;
    logic [CH_W-1:0]  out_green;
    logic [CH_W-1:0]  out_blue;
    logic [CH_W-1:0]  out_alpha;
    logic             run_last;
  } irpr_result_t;

  // Map a ratio register value to the working ratio: zero acts as one,
  // anything above the limit saturates to it.
  function automatic logic [RATIO_W-1:0] eff_ratio(input logic [RATIO_W-1:0] ratio);
    logic [RATIO_W-1:0] r;
    r = ratio;
    if (r == '0) r = RATIO_W'(1);
    if (r > RATIO_W'(MAX_RATIO)) r = RATIO_W'(MAX_RATIO);
    return r;
  endfunction

  // ceil(2^COORD_SH / r): exact floor quotient for any 9-bit coordinate
  function automatic logic [COORD_RW-1:0] recip_coord(input logic [RATIO_W-1:0] r);
    logic [COORD_RW-1:0] m;
    case (r)
      4'd2:    m = 13'd2048;
      4'd3:    m = 13'd1366;
      4'd4:    m = 13'd1024;
      4'd5:    m = 13'd820;
      4'd6:    m = 13'd683;
      4'd7:    m = 13'd586;
      4'd8:    m = 13'd512;
      default: m = 13'd4096;
    endcase
    return m;
  endfunction

  // ceil(2^AREA_SH / r^2): exact floor quotient for any 14-bit channel sum
  function automatic logic [AREA_RW-1:0] recip_area(input logic [RATIO_W-1:0] r);
    logic [AREA_RW-1:0] m;
    case (r)
      4'd2:    m = 21'd262144;
      4'd3:    m = 21'd116509;
      4'd4:    m = 21'd65536;
      4'd5:    m = 21'd41944;
      4'd6:    m = 21'd29128;
      4'd7:    m = 21'd21400;
      4'd8:    m = 21'd16384;
      default: m = 21'd1048576;
    endcase
    return m;
  endfunction

endpackage

// ===== hdl/integer_ratio_pixel_rescaler_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_ratio_pixel_rescaler_unit: integer ratio RGBA rescaler
// Box-filter downscale through a column line store, pixel replication upscale.
// ----------------------------------------------------------------------------
// Source pixels arrive in raster order with their row and column. In downscale
// mode each pixel is added into a 512-entry line store indexed by destination
// column (read, add, write back); the pixel at block offset (0,0) restarts the
// entry, and the block's bottom-right pixel yields one averaged result with
// run_last set. In upscale mode each pixel yields ratio*ratio results, row
// offset outer, column offset inner. One pixel is in work at a time: a
// downscale pixel passes the quotient, store read and write-back steps before
// the next is accepted, and one that completes a block also the average and
// emit steps, plus any wait for the output register to free up; an upscale
// pixel gives one result per cycle through the output register, unless the
// result channel stalls. The line store is not cleared after reset: a
// block whose first pixel never arrived gives undefined channels. Write
// configuration only while the unit is idle.
module integer_ratio_pixel_rescaler_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [irpr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [irpr_pkg::RATIO_W-1:0]    cfg_data,
  input  logic                            pixel_valid,
  output logic                            pixel_ready,
  input  irpr_pkg::irpr_pixel_t           pixel,
  output logic                            result_valid,
  input  logic                            result_ready,
  output irpr_pkg::irpr_result_t          result
);
  import irpr_pkg::*;

  localparam int CP_W = SRC_W + COORD_RW;
  localparam int AP_W = SUM_W + AREA_RW;

  irpr_state_t state, state_next;

  logic                 scale_mode;
  logic [RATIO_W-1:0]   scale_ratio;
  logic [RATIO_W-1:0]   r_eff;
  logic [CNT_W-1:0]     r_m1;
  logic [COORD_RW-1:0]  rc_coord;
  logic [AREA_RW-1:0]   rc_area;

  irpr_pixel_t          pix;
  logic [CH_W-1:0]      px_ch [NUM_CH];
  logic [CP_W-1:0]      row_prod, col_prod;
  logic [SRC_W-1:0]     row_q, col_q;
  logic [CNT_W-1:0]     row_rem, col_rem;
  logic                 blk_start, blk_last, col_out;

  logic [3:0][SUM_W-1:0] sum_mem [MAX_COLS];
  logic [3:0][SUM_W-1:0] mem_rdata;
  logic [3:0][SUM_W-1:0] sum_next;
  logic [3:0][SUM_W-1:0] sum_reg;
  logic [COL_AW-1:0]     mem_addr;
  logic                  mem_rd, mem_wr;

  logic [AP_W-1:0]      area_prod [NUM_CH];
  logic [SUM_W-1:0]     avg_q [NUM_CH];
  logic [CH_W-1:0]      avg_sat [NUM_CH];

  logic [CNT_W-1:0]     rep_p, rep_q;
  logic                 rep_last;
  logic [DST_W-1:0]     rep_row, rep_col;

  logic                 out_load;
  irpr_result_t         out_next;

  // Configuration registers: always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_mode  <= MODE_DOWN;
      scale_ratio <= RATIO_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SCALE_MODE:  scale_mode  <= cfg_data[0];
        CFG_SCALE_RATIO: scale_ratio <= cfg_data;
        default:         scale_mode  <= scale_mode;
      endcase
    end
  end

  // Working ratio and its reciprocals
  assign r_eff    = eff_ratio(scale_ratio);
  assign r_m1     = CNT_W'(r_eff - RATIO_W'(1));
  assign rc_coord = recip_coord(r_eff);
  assign rc_area  = recip_area(r_eff);

  // Split the latched pixel into channels
  assign px_ch[0] = pix.red;
  assign px_ch[1] = pix.green;
  assign px_ch[2] = pix.blue;
  assign px_ch[3] = pix.alpha;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (pixel_valid) state_next = (scale_mode == MODE_UP) ? ST_REP : ST_QUOT;
      ST_QUOT: state_next = ST_REM;
      ST_REM:  state_next = col_out ? ST_IDLE : ST_SUM;
      ST_SUM:  state_next = blk_last ? ST_AVG : ST_IDLE;
      ST_AVG:  state_next = ST_EMIT;
      ST_EMIT: if (out_load) state_next = ST_IDLE;
      ST_REP:  if (out_load && rep_last) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control outputs of the sequencer
  always_comb begin
    pixel_ready = 1'b0;
    mem_rd      = 1'b0;
    mem_wr      = 1'b0;
    out_load    = 1'b0;
    case (state)
      ST_IDLE: pixel_ready = 1'b1;
      ST_REM:  mem_rd = !col_out;
      ST_SUM:  mem_wr = 1'b1;
      ST_EMIT: out_load = !result_valid || result_ready;
      ST_REP:  out_load = !result_valid || result_ready;
      default: pixel_ready = 1'b0;
    endcase
  end

  // Latch the accepted pixel
  always_ff @(posedge clk) begin
    if (pixel_valid && pixel_ready) begin
      pix <= pixel;
    end
  end

  // Coordinate quotients by reciprocal multiply
  assign row_prod = CP_W'(pix.src_row) * CP_W'(rc_coord);
  assign col_prod = CP_W'(pix.src_col) * CP_W'(rc_coord);

  always_ff @(posedge clk) begin
    if (state == ST_QUOT) begin
      row_q <= row_prod[COORD_SH +: SRC_W];
      col_q <= col_prod[COORD_SH +: SRC_W];
    end
  end

  // Block offsets within the ratio-by-ratio block
  always_ff @(posedge clk) begin
    if (state == ST_REM) begin
      row_rem <= CNT_W'(pix.src_row - SRC_W'(row_q * SRC_W'(r_eff)));
      col_rem <= CNT_W'(pix.src_col - SRC_W'(col_q * SRC_W'(r_eff)));
    end
  end

  assign col_out   = (DST_W + 1)'(col_q) >= (DST_W + 1)'(MAX_COLS);
  assign blk_start = (row_rem == '0) && (col_rem == '0);
  assign blk_last  = (row_rem == r_m1) && (col_rem == r_m1);
  assign mem_addr  = COL_AW'(col_q);

  // Line store: registered read, single write port
  always_ff @(posedge clk) begin
    if (mem_wr) begin
      sum_mem[mem_addr] <= sum_next;
    end
    if (mem_rd) begin
      mem_rdata <= sum_mem[mem_addr];
    end
  end

  // Accumulate: restart at the block origin, else add and wrap
  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      sum_next[i] = blk_start ? SUM_W'(px_ch[i]) : mem_rdata[i] + SUM_W'(px_ch[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SUM) begin
      sum_reg <= sum_next;
    end
  end

  // Block average by reciprocal multiply, then saturate
  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      area_prod[i] = AP_W'(sum_reg[i]) * AP_W'(rc_area);
      avg_sat[i]   = (avg_q[i] > SUM_W'(255)) ? 8'hFF : avg_q[i][CH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_AVG) begin
      for (int i = 0; i < NUM_CH; i++) begin
        avg_q[i] <= area_prod[i][AREA_SH +: SUM_W];
      end
    end
  end

  // Replication counters: column offset inner, row offset outer
  assign rep_last = (rep_p == r_m1) && (rep_q == r_m1);
  assign rep_row  = DST_W'(pix.src_row) * DST_W'(r_eff) + DST_W'(rep_p);
  assign rep_col  = DST_W'(pix.src_col) * DST_W'(r_eff) + DST_W'(rep_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      rep_p <= '0;
      rep_q <= '0;
    end else if (state == ST_REP && out_load) begin
      if (rep_q == r_m1) begin
        rep_q <= '0;
        rep_p <= rep_last ? '0 : rep_p + CNT_W'(1);
      end else begin
        rep_q <= rep_q + CNT_W'(1);
      end
    end
  end

  // Select the result to load
  always_comb begin
    if (state == ST_REP) begin
      out_next.dst_row   = rep_row;
      out_next.dst_col   = rep_col;
      out_next.out_red   = pix.red;
      out_next.out_green = pix.green;
      out_next.out_blue  = pix.blue;
      out_next.out_alpha = pix.alpha;
      out_next.run_last  = rep_last;
    end else begin
      out_next.dst_row   = DST_W'(row_q);
      out_next.dst_col   = DST_W'(col_q);
      out_next.out_red   = avg_sat[0];
      out_next.out_green = avg_sat[1];
      out_next.out_blue  = avg_sat[2];
      out_next.out_alpha = avg_sat[3];
      out_next.run_last  = 1'b1;
    end
  end

  // Output register: hold until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result <= out_next;
    end
  end

  // Checks on the sequencer and arithmetic
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && pixel_ready |=> !pixel_ready)
    else $error("input accepted twice without completing an item");

  a_sum_after_read: assert property (@(posedge clk) disable iff (rst)
    state == ST_SUM |-> $past(state) == ST_REM)
    else $error("write-back without a preceding store read");

  a_offsets_in_block: assert property (@(posedge clk) disable iff (rst)
    state == ST_SUM |-> (RATIO_W'(row_rem) < r_eff) && (RATIO_W'(col_rem) < r_eff))
    else $error("block offset not below the ratio");

  a_rep_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_REP |-> (RATIO_W'(rep_p) < r_eff) && (RATIO_W'(rep_q) < r_eff))
    else $error("replication counter beyond the ratio");

  a_avg_bounded: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> (avg_q[0] <= sum_reg[0]) && (avg_q[1] <= sum_reg[1]) &&
                         (avg_q[2] <= sum_reg[2]) && (avg_q[3] <= sum_reg[3]))
    else $error("block average exceeds its sum");

endmodule

// ===== sim/integer_ratio_pixel_rescaler_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_ratio_pixel_rescaler_checker: result checker for the pixel rescaler
// Watches the configuration, pixel and result channels, keeps its own copy of
// the registers and the column line store, predicts every destination pixel
// and compares each result transaction field by field, oldest first.
// ----------------------------------------------------------------------------
module integer_ratio_pixel_rescaler_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [irpr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [irpr_pkg::RATIO_W-1:0]   cfg_data,
  input  logic                           pixel_valid,
  input  logic                           pixel_ready,
  input  irpr_pkg::irpr_pixel_t          pixel,
  input  logic                           result_valid,
  input  logic                           result_ready,
  input  irpr_pkg::irpr_result_t         result,
  output int                             fault_count,
  output int                             pending,
  output int                             checked_count
);
  import irpr_pkg::*;

  localparam int SHOWN_MAX = 40;

  // Shadow registers and line store
  logic               mode_q;
  logic [RATIO_W-1:0] ratio_q;
  logic [SUM_W-1:0]   line_sums [MAX_COLS][NUM_CH];

  // Destination pixels predicted but not yet seen
  irpr_result_t dst_due [$];
  int           shown;

  // Print one line for each of the first SHOWN_MAX faults and count every fault
  task automatic report_fault(input string msg);
    if (shown < SHOWN_MAX) begin
      $display("[%0t] rescaler check: %s", $time, msg);
    end
    shown++;
    fault_count++;
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      report_fault($sformatf("%s expected %0d got %0d (result %0d)",
                             name, want, got, checked_count));
    end
  endtask

  // Working ratio: zero acts as one, large values clamp to the limit
  function automatic int unsigned working_ratio(input logic [RATIO_W-1:0] value);
    int unsigned r;
    r = value;
    if (r == 0) r = 1;
    if (r > MAX_RATIO) r = MAX_RATIO;
    return r;
  endfunction

  // Predict the destination pixels caused by one source pixel
  task automatic rescale_pixel(input irpr_pixel_t px);
    int unsigned     r, dr, dc, orow, ocol, s, avg, p, q, i;
    logic [CH_W-1:0] chan [NUM_CH];
    logic [CH_W-1:0] mean [NUM_CH];
    irpr_result_t    res;
    r = working_ratio(ratio_q);
    chan[0] = px.red;
    chan[1] = px.green;
    chan[2] = px.blue;
    chan[3] = px.alpha;
    if (mode_q == MODE_DOWN) begin
      dr   = px.src_row / r;
      dc   = px.src_col / r;
      orow = px.src_row % r;
      ocol = px.src_col % r;
      if (dc < MAX_COLS) begin
        // accumulate, restart on the block's top-left pixel
        for (i = 0; i < NUM_CH; i++) begin
          if (orow == 0 && ocol == 0) s = chan[i];
          else s = (line_sums[dc][i] + chan[i]) % (1 << SUM_W);
          line_sums[dc][i] = s[SUM_W-1:0];
          avg = s / (r * r);
          mean[i] = (avg > 255) ? 8'hFF : CH_W'(avg);
        end
        if (orow == r - 1 && ocol == r - 1) begin
          res.dst_row   = DST_W'(dr);
          res.dst_col   = DST_W'(dc);
          res.out_red   = mean[0];
          res.out_green = mean[1];
          res.out_blue  = mean[2];
          res.out_alpha = mean[3];
          res.run_last  = 1'b1;
          dst_due = {dst_due, res};
        end
      end
    end else begin
      // replicate, row offset outer, column offset inner
      for (p = 0; p < r; p++) begin
        for (q = 0; q < r; q++) begin
          res.dst_row   = DST_W'(px.src_row * r + p);
          res.dst_col   = DST_W'(px.src_col * r + q);
          res.out_red   = chan[0];
          res.out_green = chan[1];
          res.out_blue  = chan[2];
          res.out_alpha = chan[3];
          res.run_last  = (p == r - 1 && q == r - 1);
          dst_due = {dst_due, res};
        end
      end
    end
  endtask

  task automatic compare_result(input irpr_result_t got);
    irpr_result_t want;
    if (dst_due.size() == 0) begin
      report_fault($sformatf("result (%0d,%0d) with nothing expected",
                             got.dst_row, got.dst_col));
    end else begin
      want = dst_due.pop_front();
      check_field("dst_row", want.dst_row, got.dst_row);
      check_field("dst_col", want.dst_col, got.dst_col);
      check_field("out_red", want.out_red, got.out_red);
      check_field("out_green", want.out_green, got.out_green);
      check_field("out_blue", want.out_blue, got.out_blue);
      check_field("out_alpha", want.out_alpha, got.out_alpha);
      check_field("run_last", want.run_last, got.run_last);
    end
    checked_count++;
  endtask

  // Track every transaction on the rising edge
  always @(posedge clk) begin
    if (rst) begin
      mode_q  = MODE_DOWN;
      ratio_q = RATIO_W'(1);
      dst_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SCALE_MODE:  mode_q = cfg_data[0];
          CFG_SCALE_RATIO: ratio_q = cfg_data;
          default: ;
        endcase
      end
      if (pixel_valid && pixel_ready) rescale_pixel(pixel);
      if (result_valid && result_ready) compare_result(result);
    end
    pending = dst_due.size();
  end

endmodule

// ===== sim/integer_ratio_pixel_rescaler_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_ratio_pixel_rescaler_unit_tb: regression bench for the rescaler
// Drives directed corner pixels, then random downscale frames and upscale
// runs under many register settings, with bursty input and a stalling result
// side. The checker beside the unit predicts and compares every result.
// ----------------------------------------------------------------------------
module integer_ratio_pixel_rescaler_unit_tb;
  import irpr_pkg::*;

  localparam int PERIOD        = 4;
  localparam int RESET_CYCLES  = 11;
  localparam int RANDOM_PIXELS = 350;
  localparam int DRAIN_CYCLES  = 16;
  localparam int LIMIT_CYCLES  = 600000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [RATIO_W-1:0]   cfg_data = '0;
  logic                 pixel_valid = 1'b0;
  logic                 pixel_ready;
  irpr_pixel_t          pixel = '0;
  logic                 result_valid;
  logic                 result_ready = 1'b0;
  irpr_result_t         result;

  int fault_count;
  int pending;
  int checked_count;

  int cycle_count = 0;
  int pixels_sent = 0;
  int directed_pixels = 0;
  int down_phases = 0;
  int up_phases = 0;
  int burst_left = 0;
  int stall_left = 0;
  int stall_style = 0;

  // Register values as the unit sees them
  logic cur_mode = MODE_DOWN;
  int   cur_ratio = 1;
  bit   col_touched [MAX_COLS];

  integer_ratio_pixel_rescaler_unit dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  integer_ratio_pixel_rescaler_checker rescale_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .pixel_valid   (pixel_valid),
    .pixel_ready   (pixel_ready),
    .pixel         (pixel),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .result        (result),
    .fault_count   (fault_count),
    .pending       (pending),
    .checked_count (checked_count)
  );

  always #(PERIOD / 2) clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Stall the result side with a changing pattern
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_left  = $urandom_range(40, 200);
    end else begin
      stall_left--;
    end
    case (stall_style)
      0:       result_ready <= 1'b1;
      1:       result_ready <= ($urandom_range(0, 1) == 0);
      2:       result_ready <= ($urandom_range(0, 3) == 0);
      default: result_ready <= (stall_left % 3 == 0);
    endcase
  end

  function automatic irpr_pixel_t make_pixel(input int row, input int col, input int r,
                                             input int g, input int b, input int a);
    irpr_pixel_t px;
    px.src_row = SRC_W'(row);
    px.src_col = SRC_W'(col);
    px.red     = CH_W'(r);
    px.green   = CH_W'(g);
    px.blue    = CH_W'(b);
    px.alpha   = CH_W'(a);
    return px;
  endfunction

  function automatic irpr_pixel_t random_pixel();
    return make_pixel($urandom_range(0, 511), $urandom_range(0, 511),
                      $urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 255), $urandom_range(0, 255));
  endfunction

  // Offer one pixel, inserting a gap at the end of each burst; valid stays up
  task automatic push_pixel(input irpr_pixel_t px);
    if (burst_left == 0) begin
      pixel_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    pixel       <= px;
    pixel_valid <= 1'b1;
    do @(posedge clk); while (!pixel_ready);
    @(negedge clk);
    burst_left--;
    pixels_sent++;
    if (cur_mode == MODE_DOWN && px.src_row % cur_ratio == 0 && px.src_col % cur_ratio == 0)
      col_touched[px.src_col / cur_ratio] = 1'b1;
  endtask

  // Hold off until every expected result is out and the unit has gone quiet
  task automatic settle();
    pixel_valid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input logic [RATIO_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
    if (idx == CFG_SCALE_MODE) begin
      cur_mode = data[0];
    end else begin
      cur_ratio = (data == 0) ? 1 : ((data > MAX_RATIO) ? MAX_RATIO : data);
    end
  endtask

  task automatic configure(input logic [RATIO_W-1:0] mode_data,
                           input logic [RATIO_W-1:0] ratio_data);
    settle();
    if ($urandom_range(0, 1) == 0) begin
      set_register(CFG_SCALE_MODE, mode_data);
      set_register(CFG_SCALE_RATIO, ratio_data);
    end else begin
      set_register(CFG_SCALE_RATIO, ratio_data);
      set_register(CFG_SCALE_MODE, mode_data);
    end
    if (cur_mode == MODE_DOWN) down_phases++;
    else up_phases++;
  endtask

  // Random pixels at random places, each replicated
  task automatic upscale_run();
    int n;
    n = $urandom_range(1, 8);
    repeat (n) push_pixel(random_pixel());
  endtask

  // Raster scan over a block-aligned window, with noise, drops and floods
  task automatic downscale_frame();
    int          r, brows, bcols, row0, col0, nrows, ncols, row, col, k;
    bit          flooded;
    irpr_pixel_t px;
    r       = cur_ratio;
    flooded = 1'b0;
    brows   = (r > 4) ? 1 : $urandom_range(1, 2);
    bcols   = (r > 4) ? 1 : $urandom_range(1, 3);
    row0    = $urandom_range(0, 512 / r - brows) * r;
    col0    = $urandom_range(0, 512 / r - bcols) * r;
    nrows   = brows * r;
    ncols   = bcols * r;
    // uneven frame: a partial block row or column that never completes
    if ($urandom_range(0, 4) == 0 && row0 + nrows <= 511) nrows++;
    if ($urandom_range(0, 4) == 0 && col0 + ncols <= 511) ncols++;
    for (row = row0; row < row0 + nrows; row++) begin
      for (col = col0; col < col0 + ncols; col++) begin
        // noise: a stray pixel whose line store entry is already defined
        if ($urandom_range(0, 15) == 0) begin
          px = random_pixel();
          if ((px.src_row % r == 0 && px.src_col % r == 0) || col_touched[px.src_col / r])
            push_pixel(px);
        end
        // flood: repeat one pixel 60 to 80 times so the sums saturate or wrap
        if (!flooded && (row % r != 0 || col % r != 0) && $urandom_range(0, 40) == 0) begin
          k = $urandom_range(60, 80);
          repeat (k) push_pixel(make_pixel(row, col, 255, 255, 255, 255));
          flooded = 1'b1;
        end
        // drop an occasional pixel, never a block start
        if ((row % r != 0 || col % r != 0) && $urandom_range(0, 19) == 0) continue;
        push_pixel(make_pixel(row, col, $urandom_range(0, 255), $urandom_range(0, 255),
                              $urandom_range(0, 255), $urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset registers: downscale at ratio one, every pixel its own block
    push_pixel(make_pixel(0, 0, 0, 0, 0, 0));
    push_pixel(make_pixel(511, 511, 255, 255, 255, 255));
    push_pixel(make_pixel(170, 85, 8'hAA, 8'h55, 8'h0F, 8'hF0));

    // Ratio zero acts as ratio one
    configure(4'h0, 4'h0);
    push_pixel(make_pixel(300, 5, 1, 2, 3, 4));

    // Upscale at one, the largest ratio, a clamped ratio and three
    configure(4'h1, 4'h1);
    push_pixel(make_pixel(7, 9, 10, 20, 30, 40));
    configure(4'h1, 4'h8);
    push_pixel(make_pixel(511, 511, 255, 0, 255, 0));
    configure(4'hF, 4'hF);
    push_pixel(make_pixel(0, 0, 0, 255, 0, 255));
    configure(4'h3, 4'h3);
    push_pixel(make_pixel(256, 170, 128, 127, 1, 254));

    // Downscale by two: a plain block, a saturating block, a partial block
    configure(4'hE, 4'h2);
    push_pixel(make_pixel(0, 0, 10, 200, 3, 255));
    push_pixel(make_pixel(0, 1, 11, 201, 4, 255));
    push_pixel(make_pixel(1, 0, 12, 202, 5, 254));
    push_pixel(make_pixel(1, 1, 13, 203, 6, 255));
    push_pixel(make_pixel(2, 2, 255, 255, 255, 255));
    push_pixel(make_pixel(2, 3, 255, 255, 255, 255));
    push_pixel(make_pixel(2, 3, 255, 255, 255, 255));
    push_pixel(make_pixel(3, 2, 255, 255, 255, 255));
    push_pixel(make_pixel(3, 3, 255, 255, 255, 255));
    push_pixel(make_pixel(4, 4, 9, 9, 9, 9));
    directed_pixels = pixels_sent;

    // Random phases, each under fresh register values
    while (pixels_sent - directed_pixels < RANDOM_PIXELS) begin
      configure(RATIO_W'($urandom_range(0, 15)),
                ($urandom_range(0, 2) == 0) ? RATIO_W'($urandom_range(0, 15))
                                            : RATIO_W'($urandom_range(1, 4)));
      if (cur_mode == MODE_UP) upscale_run();
      else downscale_frame();
    end

    settle();
    $display("Covered %0d source pixels (%0d directed) over %0d downscale and %0d upscale phases",
             pixels_sent, directed_pixels, down_phases, up_phases);
    $display("Compared %0d destination pixels, %0d mismatches", checked_count, fault_count);
    if (fault_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
